/* design/block_scaled_int8_dot_accumulate_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block scaled int8 dot accumulate unit
// Shared helpers for concurrent checks on clocked, reset-qualified properties
// ----------------------------------------------------------------------------
`ifndef BLOCK_SCALED_INT8_DOT_ACCUMULATE_UNIT_MACROS_SVH
`define BLOCK_SCALED_INT8_DOT_ACCUMULATE_UNIT_MACROS_SVH

// same-cycle implication
`define BSDOT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsdot check failed");

// next-cycle implication
`define BSDOT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsdot check failed");

`endif

/* design/bsdot_pkg.sv */
// ----------------------------------------------------------------------------
// bsdot_pkg
// Types, constants and helpers of the block scaled int8 dot accumulate unit
// ----------------------------------------------------------------------------
package bsdot_pkg;

  localparam int GroupWidth = 4;
  localparam int GrpIdxW    = (GroupWidth > 1) ? $clog2(GroupWidth) : 1;
  localparam int PsBits     = 17;
  localparam int MagW       = 80;
  localparam int ExpW       = 12;

  localparam logic [31:0] QNaN   = 32'h7FC0_0000;
  localparam logic [31:0] PosInf = 32'h7F80_0000;

  typedef struct packed {
    logic signed [7:0] act_0;
    logic signed [7:0] act_1;
    logic signed [7:0] act_2;
    logic signed [7:0] act_3;
    logic signed [3:0] wt_0;
    logic signed [3:0] wt_1;
    logic signed [3:0] wt_2;
    logic signed [3:0] wt_3;
    logic [31:0]       act_scale;
    logic [31:0]       wt_scale;
    logic              block_end;
    logic              row_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] dot_result;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic                     start;
    logic signed [PsBits-1:0] ps;
    logic [31:0]              act_scale;
    logic [31:0]              wt_scale;
    logic [31:0]              acc;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fp_rsp_t;

  typedef struct packed {
    logic        sign;
    logic [23:0] man;
    logic [7:0]  expo;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_dec_t;

  function automatic fp_dec_t fp_decode(input logic [31:0] b);
    fp_dec_t d;
    d.sign = b[31];
    d.man  = {(b[30:23] != 8'd0), b[22:0]};
    d.expo = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    d.zero = (b[30:0] == 31'd0);
    d.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    d.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    return d;
  endfunction

endpackage

/* design/bsdot_if.sv */
// ----------------------------------------------------------------------------
// bsdot channel interfaces
// Valid/ready channels for input groups and finished dot products
// ----------------------------------------------------------------------------
interface bsdot_in_if;
  logic                 valid;
  logic                 ready;
  bsdot_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsdot_out_if;
  logic                 valid;
  logic                 ready;
  bsdot_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/bsdot_mac.sv */
// ----------------------------------------------------------------------------
// bsdot_mac
// Integer partial sum: one int8 x int4 product added per cycle
// ----------------------------------------------------------------------------
module bsdot_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsdot_pkg::mac_ctl_t                 ctl_i,
  input  bsdot_pkg::in_item_t                 item_i,
  output logic                                done_o,
  output logic signed [bsdot_pkg::PsBits-1:0] ps_o
);

  localparam int PW = bsdot_pkg::PsBits;
  localparam int IW = bsdot_pkg::GrpIdxW;

  logic                  busy_q;
  logic [IW-1:0]         idx_q;
  logic signed [PW-1:0]  ps_q;
  logic signed [PW-1:0]  ps_d;
  logic signed [7:0]     act_sel;
  logic signed [3:0]     wt_sel;
  logic signed [11:0]    prod;

  always_comb begin
    case (idx_q)
      IW'(0): begin
        act_sel = item_i.act_0;
        wt_sel  = item_i.wt_0;
      end
      IW'(1): begin
        act_sel = item_i.act_1;
        wt_sel  = item_i.wt_1;
      end
      IW'(2): begin
        act_sel = item_i.act_2;
        wt_sel  = item_i.wt_2;
      end
      default: begin
        act_sel = item_i.act_3;
        wt_sel  = item_i.wt_3;
      end
    endcase
  end

  assign prod   = act_sel * wt_sel;
  assign ps_d   = ps_q + {{(PW-12){prod[11]}}, prod};
  assign done_o = busy_q && (idx_q == IW'(bsdot_pkg::GroupWidth - 1));
  assign ps_o   = ps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ps_q   <= '0;
    end else begin
      if (ctl_i.clear) begin
        ps_q <= '0;
      end
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        ps_q  <= ps_d;
        idx_q <= idx_q + IW'(1);
        if (done_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* design/bsdot_fpu.sv */
// ----------------------------------------------------------------------------
// bsdot_fpu
// Block scale step: fp32 round of sum x weight scale, then fused multiply-add
// into the accumulator, on one multiplier and one shared shift/round datapath
// ----------------------------------------------------------------------------
module bsdot_fpu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsdot_pkg::fp_req_t  req_i,
  output bsdot_pkg::fp_rsp_t  rsp_o
);

  localparam int MW  = bsdot_pkg::MagW;
  localparam int EW  = bsdot_pkg::ExpW;
  localparam int PW  = bsdot_pkg::PsBits;
  localparam int Sh1 = MW - 1 - (PW + 24);
  localparam int Sh2 = MW - 1 - 48;
  localparam int Sh3 = MW - 1 - 24;

  localparam logic signed [EW-1:0] Off1  = EW'(150 + Sh1);
  localparam logic signed [EW-1:0] Off2  = EW'(300 + Sh2);
  localparam logic signed [EW-1:0] Off3  = EW'(150 + Sh3);
  localparam logic signed [EW-1:0] BiasN = EW'(127 + MW - 2);

  localparam logic [3:0] FIdle   = 4'd0;
  localparam logic [3:0] FChk1   = 4'd1;
  localparam logic [3:0] FMul2   = 4'd2;
  localparam logic [3:0] FAlign  = 4'd3;
  localparam logic [3:0] FAdd    = 4'd4;
  localparam logic [3:0] FNorm   = 4'd5;
  localparam logic [3:0] FDenorm = 4'd6;
  localparam logic [3:0] FRnd    = 4'd7;
  localparam logic [3:0] FDone   = 4'd8;

  function automatic logic signed [EW-1:0] ext8(input logic [7:0] x);
    return $signed({{(EW-8){1'b0}}, x});
  endfunction

  function automatic logic [MW-1:0] shr1(input logic [MW-1:0] m);
    return {1'b0, m[MW-1:2], m[1] | m[0]};
  endfunction

  function automatic logic [MW-1:0] shr8(input logic [MW-1:0] m);
    return {8'b0, m[MW-1:9], |m[8:0]};
  endfunction

  logic [3:0]           state_q, state_d;
  logic                 phase_q, phase_d;
  logic signed [PW-1:0] ps_q, ps_d;
  logic [31:0]          wsc_q, wsc_d;
  logic [31:0]          asc_q, asc_d;
  logic [31:0]          accin_q, accin_d;
  logic [31:0]          prod_q, prod_d;
  logic [31:0]          res_q, res_d;
  logic [MW-1:0]        main_q, main_d;
  logic [MW-1:0]        aux_q, aux_d;
  logic signed [EW-1:0] em_q, em_d;
  logic signed [EW-1:0] ea_q, ea_d;
  logic                 sm_q, sm_d;
  logic                 sa_q, sa_d;

  bsdot_pkg::fp_dec_t   wd, pd, xd, cd;
  logic [PW-1:0]        ps_abs;
  logic                 sgn1, ps_zero, sp, pinf, pzero;
  logic [23:0]          mul_a, mul_b;
  logic [47:0]          mul;
  logic signed [EW-1:0] dexp, bexp, fexp;
  logic [23:0]          keep;
  logic                 guard, sticky, round_up, ovf;
  logic [24:0]          keep25;
  logic [31:0]          rnd;

  assign wd      = bsdot_pkg::fp_decode(wsc_q);
  assign pd      = bsdot_pkg::fp_decode(prod_q);
  assign xd      = bsdot_pkg::fp_decode(asc_q);
  assign cd      = bsdot_pkg::fp_decode(accin_q);
  assign ps_abs  = ps_q[PW-1] ? PW'(-ps_q) : PW'(ps_q);
  assign ps_zero = (ps_q == '0);
  assign sgn1    = wsc_q[31] ^ ps_q[PW-1];
  assign sp      = prod_q[31] ^ asc_q[31];
  assign pinf    = pd.inf | xd.inf;
  assign pzero   = pd.zero | xd.zero;

  // one multiplier serves both the weight scale and the activation scale step
  always_comb begin
    if (state_q == FMul2) begin
      mul_a = pd.man;
      mul_b = xd.man;
    end else begin
      mul_a = {{(24-PW){1'b0}}, ps_abs};
      mul_b = wd.man;
    end
  end
  assign mul = mul_a * mul_b;

  assign dexp = em_q - ea_q;

  // round to nearest even from the normalized magnitude
  assign keep     = main_q[MW-2 -: 24];
  assign guard    = main_q[MW-26];
  assign sticky   = |main_q[MW-27:0];
  assign round_up = guard & (sticky | keep[0]);
  assign keep25   = {1'b0, keep} + 25'(round_up);
  assign bexp     = em_q + BiasN;
  always_comb begin
    if (keep25[24]) begin
      fexp = bexp + EW'(1);
    end else if (keep25[23]) begin
      fexp = bexp;
    end else begin
      fexp = '0;
    end
  end
  assign ovf = (fexp >= EW'(255));
  assign rnd = ovf ? {sm_q, bsdot_pkg::PosInf[30:0]}
                   : {sm_q, fexp[7:0], (keep25[24] ? 23'd0 : keep25[22:0])};

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ps_d    = ps_q;
    wsc_d   = wsc_q;
    asc_d   = asc_q;
    accin_d = accin_q;
    prod_d  = prod_q;
    res_d   = res_q;
    main_d  = main_q;
    aux_d   = aux_q;
    em_d    = em_q;
    ea_d    = ea_q;
    sm_d    = sm_q;
    sa_d    = sa_q;
    case (state_q)
      FIdle: begin
        if (req_i.start) begin
          ps_d    = req_i.ps;
          wsc_d   = req_i.wt_scale;
          asc_d   = req_i.act_scale;
          accin_d = req_i.acc;
          state_d = FChk1;
        end
      end
      FChk1: begin
        if (wd.nan || (wd.inf && ps_zero)) begin
          prod_d  = bsdot_pkg::QNaN;
          state_d = FMul2;
        end else if (wd.inf) begin
          prod_d  = {sgn1, bsdot_pkg::PosInf[30:0]};
          state_d = FMul2;
        end else if (wd.zero || ps_zero) begin
          prod_d  = {sgn1, 31'd0};
          state_d = FMul2;
        end else begin
          main_d  = {1'b0, mul[PW+23:0], {Sh1{1'b0}}};
          em_d    = ext8(wd.expo) - Off1;
          sm_d    = sgn1;
          phase_d = 1'b0;
          state_d = FNorm;
        end
      end
      FMul2: begin
        if (pd.nan || xd.nan || cd.nan || (pinf && pzero) ||
            (pinf && cd.inf && (sp != cd.sign))) begin
          res_d   = bsdot_pkg::QNaN;
          state_d = FDone;
        end else if (pinf) begin
          res_d   = {sp, bsdot_pkg::PosInf[30:0]};
          state_d = FDone;
        end else if (cd.inf) begin
          res_d   = accin_q;
          state_d = FDone;
        end else if (pzero) begin
          res_d   = cd.zero ? {sp & cd.sign, 31'd0} : accin_q;
          state_d = FDone;
        end else begin
          main_d  = {1'b0, mul, {Sh2{1'b0}}};
          em_d    = ext8(pd.expo) + ext8(xd.expo) - Off2;
          sm_d    = sp;
          aux_d   = {1'b0, cd.man, {Sh3{1'b0}}};
          ea_d    = ext8(cd.expo) - Off3;
          sa_d    = cd.sign;
          phase_d = 1'b1;
          state_d = cd.zero ? FNorm : FAlign;
        end
      end
      FAlign: begin
        if (dexp < 0) begin
          main_d = aux_q;
          aux_d  = main_q;
          em_d   = ea_q;
          ea_d   = em_q;
          sm_d   = sa_q;
          sa_d   = sm_q;
        end else if (dexp == 0) begin
          state_d = FAdd;
        end else if (dexp >= 88) begin
          aux_d   = {{(MW-1){1'b0}}, |aux_q};
          ea_d    = em_q;
          state_d = FAdd;
        end else if (dexp >= 8) begin
          aux_d = shr8(aux_q);
          ea_d  = ea_q + EW'(8);
        end else begin
          aux_d = shr1(aux_q);
          ea_d  = ea_q + EW'(1);
        end
      end
      FAdd: begin
        if (sm_q == sa_q) begin
          main_d = main_q + aux_q;
        end else if (main_q == aux_q) begin
          main_d = '0;
          sm_d   = 1'b0;
        end else if (main_q > aux_q) begin
          main_d = main_q - aux_q;
        end else begin
          main_d = aux_q - main_q;
          sm_d   = sa_q;
        end
        state_d = FNorm;
      end
      FNorm: begin
        if (main_q == '0) begin
          res_d   = {sm_q, 31'd0};
          state_d = FDone;
        end else if (main_q[MW-1]) begin
          main_d = shr1(main_q);
          em_d   = em_q + EW'(1);
        end else if (main_q[MW-2 -: 8] == 8'd0) begin
          main_d = main_q << 8;
          em_d   = em_q - EW'(8);
        end else if (!main_q[MW-2]) begin
          main_d = main_q << 1;
          em_d   = em_q - EW'(1);
        end else begin
          state_d = FDenorm;
        end
      end
      FDenorm: begin
        if (bexp <= -7) begin
          main_d = shr8(main_q);
          em_d   = em_q + EW'(8);
        end else if (bexp < 1) begin
          main_d = shr1(main_q);
          em_d   = em_q + EW'(1);
        end else begin
          state_d = FRnd;
        end
      end
      FRnd: begin
        if (phase_q) begin
          res_d   = rnd;
          state_d = FDone;
        end else begin
          prod_d  = rnd;
          state_d = FMul2;
        end
      end
      FDone: begin
        state_d = FIdle;
      end
      default: begin
        state_d = FIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q    <= ps_d;
    wsc_q   <= wsc_d;
    asc_q   <= asc_d;
    accin_q <= accin_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
    main_q  <= main_d;
    aux_q   <= aux_d;
    em_q    <= em_d;
    ea_q    <= ea_d;
    sm_q    <= sm_d;
    sa_q    <= sa_d;
  end

  assign rsp_o.done   = (state_q == FDone);
  assign rsp_o.result = res_q;

endmodule

/* design/block_scaled_int8_dot_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// block_scaled_int8_dot_accumulate_unit
// One output element of a block-quantized int8 x int4 matrix product
// ----------------------------------------------------------------------------
// in_i carries one k group per transaction: four int8 activations, four
// centered 4-bit weights, both fp32 block scales and the block_end and
// row_end marks. out_o carries the fp32 dot product once per row_end group.
// A group runs its GroupWidth products in turn on the shared int8 x int4
// multiply-add, and the next group is accepted only once it is through.
// On block_end the fp sequencer runs after the multiply-add: its single
// shifter normalizes and aligns 8 or 1 bit per cycle and runs twice (weight
// scale product, then fused multiply-add with the activation scale).
// in_i.ready is high only while the block is idle.
// The result sits in an output register; the next group is accepted while
// it waits, and a later row_end group stalls only until out_o takes it.
// Reset clears the partial sum to 0 and the accumulator to +0.
// ----------------------------------------------------------------------------
module block_scaled_int8_dot_accumulate_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsdot_in_if.sink           in_i,
  bsdot_out_if.source        out_o
);

  localparam logic [2:0] TIdle = 3'd0;
  localparam logic [2:0] TMac  = 3'd1;
  localparam logic [2:0] TFpGo = 3'd2;
  localparam logic [2:0] TFp   = 3'd3;
  localparam logic [2:0] TEmit = 3'd4;

  logic [2:0]                                state_q, state_d;
  bsdot_pkg::in_item_t                       item_q;
  logic [31:0]                               acc_q, acc_d;
  logic [31:0]                               out_q, out_d;
  logic                                      out_valid_q, out_valid_d;
  logic                                      accept;
  logic                                      emit;
  logic                                      mac_done;
  logic signed [bsdot_pkg::PsBits-1:0]       mac_ps;
  bsdot_pkg::mac_ctl_t                       mac_ctl;
  bsdot_pkg::fp_req_t                        fp_req;
  bsdot_pkg::fp_rsp_t                        fp_rsp;

  assign in_i.ready = (state_q == TIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign emit       = (state_q == TEmit) && item_q.row_end &&
                      (!out_valid_q || out_o.ready);

  assign mac_ctl.start = accept;
  assign mac_ctl.clear = (state_q == TFp) && fp_rsp.done;

  bsdot_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .item_i (item_q),
    .done_o (mac_done),
    .ps_o   (mac_ps)
  );

  assign fp_req.start     = (state_q == TFpGo);
  assign fp_req.ps        = mac_ps;
  assign fp_req.act_scale = item_q.act_scale;
  assign fp_req.wt_scale  = item_q.wt_scale;
  assign fp_req.acc       = acc_q;

  bsdot_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fp_req),
    .rsp_o  (fp_rsp)
  );

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      TIdle: begin
        if (accept) begin
          state_d = TMac;
        end
      end
      TMac: begin
        if (mac_done) begin
          state_d = item_q.block_end ? TFpGo : TEmit;
        end
      end
      TFpGo: begin
        state_d = TFp;
      end
      TFp: begin
        if (fp_rsp.done) begin
          acc_d   = fp_rsp.result;
          state_d = TEmit;
        end
      end
      TEmit: begin
        if (!item_q.row_end) begin
          state_d = TIdle;
        end else if (emit) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
          acc_d       = '0;
          state_d     = TIdle;
        end
      end
      default: begin
        state_d = TIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TIdle;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      item_q <= in_i.data;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.data.dot_result = out_q;

endmodule

/* design/bsdot_chk.sv */
// ----------------------------------------------------------------------------
// bsdot_chk
// Port-level checks of the block scaled int8 dot accumulate unit
// ----------------------------------------------------------------------------
`include "block_scaled_int8_dot_accumulate_unit_macros.svh"

module bsdot_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  `BSDOT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BSDOT_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))
  // a group occupies the multiply-add after it is accepted, so in_ready stays low
  `BSDOT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i ##1 !in_ready_i)
  // a result only appears at the end of a group's processing
  `BSDOT_ASSERT_IMP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind block_scaled_int8_dot_accumulate_unit bsdot_chk u_bsdot_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data.dot_result)
);

/* bench/bsdot_checker.sv */
// ----------------------------------------------------------------------------
// bsdot_checker
// Watches both channels of the dot accumulate unit. It predicts each finished
// dot product from the accepted groups and compares it with the result seen
// on the output channel.
// ----------------------------------------------------------------------------
module bsdot_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsdot_in_if   in_mon_i,
  bsdot_out_if  out_mon_i,
  output int    errors_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = bsdot_pkg::PsBits;

  logic signed [PW-1:0] grp_sum;
  logic [31:0]          row_accum;
  logic [31:0]          dot_expected_q[$];

  function automatic real fp32_to_real(input logic [31:0] b);
    real         r;
    logic [10:0] e;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    end
    if (b[30:23] == 8'd0) begin
      r = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -r : r;
    end
    e = 11'(b[30:23]) + 11'd896;
    return $bitstoreal({b[31], e, b[22:0], 29'd0});
  endfunction

  // round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_fp32(input real d);
    logic [63:0] db;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic        s;
    int          ex;
    int          sh;
    db = $realtobits(d);
    s  = db[63];
    if (db[62:52] == 11'h7FF) begin
      return (db[51:0] != 52'd0) ? bsdot_pkg::QNaN : {s, bsdot_pkg::PosInf[30:0]};
    end
    if (db[62:52] == 11'd0) begin
      return {s, 31'd0};
    end
    ex  = int'(db[62:52]) - 1023;
    sig = {11'd0, 1'b1, db[51:0]};
    sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 62) begin
      return {s, 31'd0};
    end
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) begin
      kept = kept + 64'd1;
    end
    if (ex >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        ex   = ex + 1;
      end
      if (ex > 127) begin
        return {s, bsdot_pkg::PosInf[30:0]};
      end
      return {s, 8'(ex + 127), kept[22:0]};
    end
    return {s, kept[30:0]};
  endfunction

  // acc + x*y, one rounding: exact product, sum rounded to odd in double
  function automatic logic [31:0] fused_scale_add(input logic [31:0] acc,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y);
    real         p;
    real         a;
    real         s;
    real         bv;
    real         err;
    logic [63:0] sb;
    p = fp32_to_real(x) * fp32_to_real(y);
    a = fp32_to_real(acc);
    s = p + a;
    if (s - s == 0.0) begin
      bv  = s - p;
      err = (p - (s - bv)) + (a - bv);
      if (err != 0.0) begin
        sb = $realtobits(s);
        if (!sb[0]) begin
          sb = ((err > 0.0) == (s > 0.0)) ? sb + 64'd1 : sb - 64'd1;
          s  = $bitstoreal(sb);
        end
      end
    end
    return real_to_fp32(s);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bsdot_pkg::in_item_t  it;
    logic signed [PW-1:0] nsum;
    logic [31:0]          nacc;
    logic [31:0]          wprod;
    logic [31:0]          want;
    if (!rst_ni) begin
      grp_sum   <= '0;
      row_accum <= '0;
      errors_o  <= 0;
      pending_o <= 0;
      dot_expected_q.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (dot_expected_q.size() == 0) begin
          $error("unexpected dot_result %h", out_mon_i.data.dot_result);
          errors_o <= errors_o + 1;
        end else begin
          want = dot_expected_q.pop_front();
          if (out_mon_i.data.dot_result !== want) begin
            $error("dot_result expected %h actual %h", want,
                   out_mon_i.data.dot_result);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        it   = in_mon_i.data;
        nsum = grp_sum
             + PW'(it.act_0) * PW'(it.wt_0) + PW'(it.act_1) * PW'(it.wt_1)
             + PW'(it.act_2) * PW'(it.wt_2) + PW'(it.act_3) * PW'(it.wt_3);
        nacc = row_accum;
        if (it.block_end) begin
          wprod = real_to_fp32(real'(nsum) * fp32_to_real(it.wt_scale));
          nacc  = fused_scale_add(nacc, wprod, it.act_scale);
          nsum  = '0;
        end
        if (it.row_end) begin
          dot_expected_q.push_back(nacc);
          nacc = '0;
        end
        grp_sum   <= nsum;
        row_accum <= nacc;
      end
      pending_o <= dot_expected_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives k groups into the dot accumulate unit: directed corner groups, then
// random rows of blocks with random idling, a long output hold-off and a
// drain pause. The checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors;
  int   pending;
  bit   steady;
  bit   hold_off;

  bsdot_in_if  in_if ();
  bsdot_out_if out_if ();

  block_scaled_int8_dot_accumulate_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bsdot_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_if),
    .out_mon_i (out_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 19))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {1'($urandom), bsdot_pkg::PosInf[30:0]};
      3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      4: return {1'($urandom), 8'd0, 23'($urandom)};
      5: return {1'($urandom), 31'h7F7F_FFFF};
      6: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  function automatic bsdot_pkg::in_item_t rand_group(input bit blk, input bit row);
    bsdot_pkg::in_item_t it;
    it           = bsdot_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.act_scale = pick_scale();
    it.wt_scale  = pick_scale();
    it.block_end = blk;
    it.row_end   = row;
    return it;
  endfunction

  task automatic send(input bsdot_pkg::in_item_t it);
    if (!steady && $urandom_range(0, 99) < 28) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // receiver
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_if.ready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    bsdot_pkg::in_item_t it;
    int                  nblk;
    int                  ngrp;
    int                  sent;
    bit                  held;
    bit                  drained;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    steady      = 1'b0;
    hold_off    = 1'b0;
    held        = 1'b0;
    drained     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // partial sum wraps: 17 groups of +4096
    for (int i = 0; i < 17; i++) begin
      it = '{act_0: -8'sd128, act_1: -8'sd128, act_2: -8'sd128, act_3: -8'sd128,
             wt_0: -4'sd8, wt_1: -4'sd8, wt_2: -4'sd8, wt_3: -4'sd8,
             act_scale: 32'h3F80_0000, wt_scale: 32'h3F80_0000,
             block_end: (i == 16), row_end: (i == 16)};
      send(it);
    end
    // extreme positive products, nan and inf scales
    it = '{8'sd127, 8'sd127, 8'sd127, 8'sd127, 4'sd7, 4'sd7, 4'sd7, 4'sd7,
           32'h7FC1_2345, 32'h3F80_0000, 1'b1, 1'b1};
    send(it);
    it.act_scale = bsdot_pkg::PosInf;
    it.wt_scale  = 32'h0000_0000;
    send(it);
    it.act_scale = 32'h7F7F_FFFF;
    it.wt_scale  = 32'h7F7F_FFFF;
    send(it);
    // subnormal scales
    it.act_scale = 32'h0000_0001;
    it.wt_scale  = 32'h807F_FFFF;
    send(it);
    // row end without block end, partial sum carries over
    it.block_end = 1'b0;
    send(it);
    it.act_0     = -8'sd1;
    it.act_scale = 32'h4000_0000;
    it.wt_scale  = 32'hBF80_0000;
    it.block_end = 1'b1;
    send(it);

    // random rows of blocks
    sent = 0;
    while (sent < 1800) begin
      steady = (sent >= 600 && sent < 800);
      if (!held && sent >= 300) begin
        held     = 1'b1;
        hold_off = 1'b1;
      end
      if (!drained && sent >= 1200) begin
        drained = 1'b1;
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      nblk = $urandom_range(1, 4);
      for (int b = 0; b < nblk; b++) begin
        ngrp = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 8;
        for (int g = 0; g < ngrp; g++) begin
          if ($urandom_range(0, 19) == 0) begin
            it = rand_group(1'($urandom), 1'($urandom));
          end else begin
            it = rand_group(g == ngrp - 1, (g == ngrp - 1) && (b == nblk - 1));
          end
          send(it);
          sent++;
        end
      end
    end
    in_if.valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
